FILE: hw/rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, character codes and the command layout table of the
// telescope set-command parser.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // Command codes as reported on the result.
  localparam logic [2:0] KIND_SR      = 3'd0;
  localparam logic [2:0] KIND_SD      = 3'd1;
  localparam logic [2:0] KIND_SG      = 3'd2;
  localparam logic [2:0] KIND_ST      = 3'd3;
  localparam logic [2:0] KIND_SL      = 3'd4;
  localparam logic [2:0] KIND_SC      = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;

  // Character codes.
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_S = 8'h53;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_D  = 8'h64;
  localparam logic [7:0] CH_LOW_G  = 8'h67;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_C   = 8'h43;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DEGREE = 8'hDF;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Width of the string position counter (prefix of three plus at most ten).
  localparam int POS_W = 4;

  // Element kinds of a command body layout.
  typedef enum logic [3:0] {
    EL_NONE  = 4'd0,  // past the end of the layout
    EL_SIGN  = 4'd1,  // optional '+' or '-'
    EL_DOPT  = 4'd2,  // optional extra digit of the first number
    EL_D     = 4'd3,  // digit of the first number
    EL_E     = 4'd4,  // digit of the second number
    EL_F     = 4'd5,  // digit of the third number
    EL_DEG   = 4'd6,  // degree sign
    EL_HASH  = 4'd7,  // terminator
    EL_COLON = 4'd8,
    EL_SLASH = 4'd9
  } elem_t;

  // A finished command string, handed from the parser to the result stage.
  typedef struct packed {
    logic [2:0] code;
    logic       good;
    logic       negative;
    logic [9:0] first;
    logic [6:0] second;
    logic [6:0] third;
  } snap_t;

  // Layout element at body index idx of command kind.
  function automatic elem_t layout_elem(input logic [2:0] kind, input logic [POS_W-1:0] idx);
    elem_t e;
    e = EL_NONE;
    unique case (kind)
      KIND_SR, KIND_SL, KIND_SC: begin
        // DD:EE:FF# (date uses slashes)
        unique case (idx)
          4'd0, 4'd1: e = EL_D;
          4'd2, 4'd5: e = (kind == KIND_SC) ? EL_SLASH : EL_COLON;
          4'd3, 4'd4: e = EL_E;
          4'd6, 4'd7: e = EL_F;
          4'd8:       e = EL_HASH;
          default:    e = EL_NONE;
        endcase
      end
      KIND_SD: begin
        // SDD*EE:FF#
        unique case (idx)
          4'd0:       e = EL_SIGN;
          4'd1, 4'd2: e = EL_D;
          4'd3:       e = EL_DEG;
          4'd4, 4'd5: e = EL_E;
          4'd6:       e = EL_COLON;
          4'd7, 4'd8: e = EL_F;
          4'd9:       e = EL_HASH;
          default:    e = EL_NONE;
        endcase
      end
      KIND_SG: begin
        // SDDd*EE#
        unique case (idx)
          4'd0:       e = EL_SIGN;
          4'd1, 4'd2: e = EL_D;
          4'd3:       e = EL_DOPT;
          4'd4:       e = EL_DEG;
          4'd5, 4'd6: e = EL_E;
          4'd7:       e = EL_HASH;
          default:    e = EL_NONE;
        endcase
      end
      KIND_ST: begin
        // SDD*EE#
        unique case (idx)
          4'd0:       e = EL_SIGN;
          4'd1, 4'd2: e = EL_D;
          4'd3:       e = EL_DEG;
          4'd4, 4'd5: e = EL_E;
          4'd6:       e = EL_HASH;
          default:    e = EL_NONE;
        endcase
      end
      default: e = EL_NONE;
    endcase
    return e;
  endfunction

endpackage

FILE: hw/rtl/tsc_parse.sv
// ----------------------------------------------------------------------------
// tsc_parse
// Input register and byte parser. Each byte updates the parse state; the
// last byte of a string produces a snapshot for the result stage.
// ----------------------------------------------------------------------------
module tsc_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] char_byte
  input  logic             s_tlast,   // end_of_string
  output logic             snap_valid,
  input  logic             snap_ready,
  output tsc_pkg::snap_t   snap
);
  import tsc_pkg::*;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Parse state.
  logic [POS_W-1:0] pos, pos_next;
  logic [2:0]       kind, kind_next;
  logic             negative, negative_next;
  logic [9:0]       first, first_next;
  logic [6:0]       second, second_next;
  logic [6:0]       third, third_next;
  logic             failed, failed_next;
  logic             term, term_next;

  logic             consume;
  logic             is_dig;
  logic [3:0]       dig_val;
  logic [9:0]       first_mac;
  logic [6:0]       second_mac;
  logic [6:0]       third_mac;
  logic [POS_W-1:0] idx;
  elem_t            cur_el;
  elem_t            nxt_el;
  elem_t            eff_el;
  logic             fall;
  logic [POS_W-1:0] base;

  // The parser takes an item unless it ends a string while the snapshot
  // register is still full.
  assign consume  = in_valid && (!in_last || !snap_valid || snap_ready);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Digit decode and accumulation, each wrapping at its field width.
  assign is_dig     = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign dig_val    = in_byte[3:0];
  assign first_mac  = first * 10'd10 + {6'd0, dig_val};
  assign second_mac = second * 7'd10 + {3'd0, dig_val};
  assign third_mac  = third * 7'd10 + {3'd0, dig_val};

  // An unmatched optional element passes the byte on to the next element.
  assign idx    = pos - POS_W'(3);
  assign cur_el = layout_elem(kind, idx);
  assign nxt_el = layout_elem(kind, idx + POS_W'(1));
  assign fall   = ((cur_el == EL_SIGN) && (in_byte != CH_MINUS) && (in_byte != CH_PLUS))
                  || ((cur_el == EL_DOPT) && !is_dig);
  assign eff_el = fall ? nxt_el : cur_el;
  assign base   = fall ? pos + POS_W'(1) : pos;

  // Next parse state for the byte in the input register.
  always_comb begin
    pos_next      = pos;
    kind_next     = kind;
    negative_next = negative;
    first_next    = first;
    second_next   = second;
    third_next    = third;
    failed_next   = failed;
    term_next     = term;
    if (!(failed || term)) begin
      priority if (pos == POS_W'(0)) begin
        if (in_byte == CH_COLON) pos_next = POS_W'(1);
        else failed_next = 1'b1;
      end else if (pos == POS_W'(1)) begin
        if (in_byte == CH_UPPER_S) pos_next = POS_W'(2);
        else failed_next = 1'b1;
      end else if (pos == POS_W'(2)) begin
        pos_next = POS_W'(3);
        unique case (in_byte)
          CH_LOW_R: kind_next = KIND_SR;
          CH_LOW_D: kind_next = KIND_SD;
          CH_LOW_G: kind_next = KIND_SG;
          CH_LOW_T: kind_next = KIND_ST;
          CH_UP_L:  kind_next = KIND_SL;
          CH_UP_C:  kind_next = KIND_SC;
          default: begin
            pos_next    = pos;
            failed_next = 1'b1;
          end
        endcase
      end else begin
        unique case (eff_el)
          EL_SIGN: begin
            pos_next = base + POS_W'(1);
            if (in_byte == CH_MINUS) negative_next = 1'b1;
          end
          EL_DOPT: begin
            pos_next   = base + POS_W'(1);
            first_next = first_mac;
          end
          EL_D: begin
            if (is_dig) begin
              first_next = first_mac;
              pos_next   = base + POS_W'(1);
            end else failed_next = 1'b1;
          end
          EL_E: begin
            if (is_dig) begin
              second_next = second_mac;
              pos_next    = base + POS_W'(1);
            end else failed_next = 1'b1;
          end
          EL_F: begin
            if (is_dig) begin
              third_next = third_mac;
              pos_next   = base + POS_W'(1);
            end else failed_next = 1'b1;
          end
          EL_DEG: begin
            if (in_byte == CH_STAR || in_byte == CH_DEGREE) pos_next = base + POS_W'(1);
            else failed_next = 1'b1;
          end
          EL_HASH: begin
            if (in_byte == CH_HASH) begin
              term_next = 1'b1;
              pos_next  = base + POS_W'(1);
            end else failed_next = 1'b1;
          end
          EL_COLON: begin
            if (in_byte == CH_COLON) pos_next = base + POS_W'(1);
            else failed_next = 1'b1;
          end
          EL_SLASH: begin
            if (in_byte == CH_SLASH) pos_next = base + POS_W'(1);
            else failed_next = 1'b1;
          end
          default: failed_next = 1'b1;
        endcase
      end
    end
  end

  // Parse state; the last byte of a string returns it to the start.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      kind     <= KIND_UNKNOWN;
      negative <= 1'b0;
      first    <= '0;
      second   <= '0;
      third    <= '0;
      failed   <= 1'b0;
      term     <= 1'b0;
    end else if (consume) begin
      if (in_last) begin
        pos      <= '0;
        kind     <= KIND_UNKNOWN;
        negative <= 1'b0;
        first    <= '0;
        second   <= '0;
        third    <= '0;
        failed   <= 1'b0;
        term     <= 1'b0;
      end else begin
        pos      <= pos_next;
        kind     <= kind_next;
        negative <= negative_next;
        first    <= first_next;
        second   <= second_next;
        third    <= third_next;
        failed   <= failed_next;
        term     <= term_next;
      end
    end
  end

  // Snapshot register holding one finished string.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (consume && in_last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
    if (consume && in_last) begin
      snap.code     <= (kind_next > KIND_SC) ? KIND_UNKNOWN : kind_next;
      snap.good     <= (kind_next <= KIND_SC) && term_next && !failed_next;
      snap.negative <= negative_next;
      snap.first    <= first_next;
      snap.second   <= second_next;
      snap.third    <= third_next;
    end
  end

endmodule

FILE: hw/rtl/tsc_result.sv
// ----------------------------------------------------------------------------
// tsc_result
// Turns a finished command into its result: range checks and the angle in
// seconds or minutes, then the output register.
// ----------------------------------------------------------------------------
module tsc_result (
  input  logic                clk,
  input  logic                rst,
  input  logic                snap_valid,
  output logic                snap_ready,
  input  tsc_pkg::snap_t      snap,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [2:0]          command_code,
  output logic                ok,
  output logic signed [19:0]  angle_value,
  output logic [9:0]          first_part,
  output logic [6:0]          second_part,
  output logic [6:0]          third_part
);
  import tsc_pkg::*;

  localparam logic [18:0] SEC_DAY_X4 = 19'd345600;
  localparam logic [18:0] SEC_DAY_X2 = 19'd172800;
  localparam logic [18:0] SEC_DAY    = 19'd86400;
  localparam logic [15:0] MIN_TURN_X2 = 16'd43200;
  localparam logic [15:0] MIN_TURN    = 16'd21600;
  localparam logic [14:0] MIN_HALF    = 15'd10800;

  // First stage: sums and range checks.
  logic        mid_valid;
  logic        mid_ready;
  snap_t       mid;
  logic [18:0] mid_sec;
  logic [15:0] mid_min;
  logic        range_ok;
  logic [18:0] sec_sum;
  logic [15:0] min_sum;
  logic        out_ready;

  assign out_ready  = !res_valid || res_ready;
  assign mid_ready  = !mid_valid || out_ready;
  assign snap_ready = mid_ready;

  // Seconds use two-digit degrees or hours; minutes may have three digits.
  assign sec_sum = {12'd0, snap.first[6:0]} * 19'd3600
                   + {12'd0, snap.second} * 19'd60 + {12'd0, snap.third};
  assign min_sum = {6'd0, snap.first} * 16'd60 + {9'd0, snap.second};

  always_comb begin
    unique case (snap.code)
      KIND_SL: range_ok = (snap.first < 10'd24) && (snap.second < 7'd60)
                          && (snap.third < 7'd60);
      KIND_SC: range_ok = (snap.first >= 10'd1) && (snap.first <= 10'd12)
                          && (snap.second >= 7'd1) && (snap.second <= 7'd31);
      default: range_ok = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= snap_valid;
    end
    if (snap_valid && mid_ready) begin
      mid      <= '{code:     snap.code,
                    good:     snap.good && range_ok,
                    negative: snap.negative,
                    first:    snap.first,
                    second:   snap.second,
                    third:    snap.third};
      mid_sec  <= sec_sum;
      mid_min  <= min_sum;
    end
  end

  // Second stage: reductions and sign handling.
  logic [18:0]        sec_r1, sec_r2, sec_r3;
  logic [15:0]        min_r1, min_r2;
  logic [14:0]        min_mod;
  logic signed [19:0] angle;

  assign sec_r1  = (mid_sec >= SEC_DAY_X4) ? mid_sec - SEC_DAY_X4 : mid_sec;
  assign sec_r2  = (sec_r1 >= SEC_DAY_X2) ? sec_r1 - SEC_DAY_X2 : sec_r1;
  assign sec_r3  = (sec_r2 >= SEC_DAY) ? sec_r2 - SEC_DAY : sec_r2;
  assign min_r1  = (mid_min >= MIN_TURN_X2) ? mid_min - MIN_TURN_X2 : mid_min;
  assign min_r2  = (min_r1 >= MIN_TURN) ? min_r1 - MIN_TURN : min_r1;
  assign min_mod = min_r2[14:0];

  always_comb begin
    unique case (mid.code)
      KIND_SR: angle = signed'({1'b0, sec_r3});
      KIND_SD: angle = mid.negative ? -signed'({1'b0, mid_sec}) : signed'({1'b0, mid_sec});
      KIND_SG: begin
        // West-positive input turned east-positive, wrapped to (-10800, 10800].
        if (mid.negative) begin
          angle = (min_mod > MIN_HALF) ? signed'({5'd0, min_mod}) - 20'sd21600
                                       : signed'({5'd0, min_mod});
        end else begin
          angle = (min_mod < MIN_HALF) ? -signed'({5'd0, min_mod})
                                       : 20'sd21600 - signed'({5'd0, min_mod});
        end
      end
      KIND_ST: angle = mid.negative ? -signed'({4'd0, mid_min}) : signed'({4'd0, mid_min});
      default: angle = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= mid_valid;
    end
    if (mid_valid && out_ready) begin
      command_code <= mid.code;
      ok           <= mid.good;
      angle_value  <= mid.good ? angle : '0;
      first_part   <= mid.good ? mid.first : '0;
      second_part  <= mid.good ? mid.second : '0;
      third_part   <= mid.good ? mid.third : '0;
    end
  end

endmodule

FILE: hw/rtl/telescope_set_command_parser.sv
// ----------------------------------------------------------------------------
// telescope_set_command_parser
// Byte-stream parser for six fixed-format telescope set commands.
// ----------------------------------------------------------------------------
// The block takes one byte of a command string per cycle while s_tready is
// high, with s_tlast on the last byte, and gives one result item for each
// string; only a last byte that meets a full, unread snapshot register waits.
// A string's result reaches the master side through the input register, the
// snapshot register, the arithmetic register and the output register in line.
// Each stage holds one item and stalls only when the stage after it is full,
// so input is still taken while a result waits to be read.
module telescope_set_command_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,   // end_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // angle_value, first_part, second_part, third_part, zero fill
  output logic [3:0]  m_tuser    // command_code, ok
);
  import tsc_pkg::*;

  logic               snap_valid;
  logic               snap_ready;
  snap_t              snap;
  logic [2:0]         command_code;
  logic               ok;
  logic signed [19:0] angle_value;
  logic [9:0]         first_part;
  logic [6:0]         second_part;
  logic [6:0]         third_part;

  tsc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  tsc_result u_result (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .command_code (command_code),
    .ok           (ok),
    .angle_value  (angle_value),
    .first_part   (first_part),
    .second_part  (second_part),
    .third_part   (third_part)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {4'd0, third_part, second_part, first_part, angle_value};
  assign m_tuser = {ok, command_code};

endmodule
